FILE: src/fsa_pkg.sv
// ----------------------------------------------------------------------------
// fsa_pkg: shared types and constants for the fraction sum accumulator
// Holds the arithmetic widths, the datapath command codes and the
// status struct that passes between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int NumW = 32;
  localparam int DenW = 31;
  localparam int CntW = 6;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CmdIdle    = 4'd0;
  localparam logic [3:0] CmdLoad    = 4'd1;
  localparam logic [3:0] CmdGcdInit = 4'd2;
  localparam logic [3:0] CmdDivInit = 4'd3;
  localparam logic [3:0] CmdDivStep = 4'd4;
  localparam logic [3:0] CmdGcdNext = 4'd5;
  localparam logic [3:0] CmdLcmDiv1 = 4'd6;
  localparam logic [3:0] CmdLcmMul  = 4'd7;
  localparam logic [3:0] CmdQ1Div   = 4'd8;
  localparam logic [3:0] CmdQ2Div   = 4'd9;
  localparam logic [3:0] CmdMul1    = 4'd10;
  localparam logic [3:0] CmdMul2    = 4'd11;
  localparam logic [3:0] CmdSum     = 4'd12;
  localparam logic [3:0] CmdZero    = 4'd13;
  localparam logic [3:0] CmdSaveQ   = 4'd14;

  typedef struct packed {
    logic div_done;
    logic gcd_zero;
    logic den_zero;
    logic lcm_zero;
  } fsa_status_t;

endpackage

FILE: src/fraction_sum_accumulator.sv
// Each item runs through the shared bit-serial divider (one quotient bit a cycle)
// for the Euclid modulo steps and three further divisions; the first item of a
// sequence is only loaded. The block takes one item at a time. The result is
// registered in the output register from the done state after the last item
// finishes. Reset (rst, synchronous) clears the sum to 0/1 and the flags.
// ----------------------------------------------------------------------------
// fraction_sum_accumulator: top level
// Adds a stream of fractions over their lcm and returns the unreduced sum.
// ----------------------------------------------------------------------------
module fraction_sum_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // numerator[31:0], denominator[62:32], pad
  input  logic        s_tlast,   // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // sum_numerator[31:0], sum_denominator[62:32], pad
  output logic        m_tuser    // overflow
);
  import fsa_pkg::*;

  fsa_status_t status;
  logic [3:0] cmd;
  logic emit, in_fire;
  logic [31:0] acc_num;
  logic [30:0] acc_den;
  logic ovf;

  assign in_fire = s_tvalid && s_tready;

  fsa_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_tlast), .out_busy(m_tvalid && !m_tready),
    .status, .cmd, .in_ready(s_tready), .emit
  );

  fsa_datapath u_dp (
    .clk, .rst, .cmd, .in_num(s_tdata[31:0]), .in_den(s_tdata[62:32]),
    .status, .acc_num, .acc_den, .ovf
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, acc_den, acc_num};
        m_tuser  <= ovf;
      end
    end
  end

endmodule

FILE: src/fsa_datapath.sv
// ----------------------------------------------------------------------------
// fsa_datapath: registers and arithmetic of the fraction sum accumulator
// One restoring divider shared by the GCD loop, the lcm and the scale factors,
// an unsigned and a signed multiplier, and the running sum registers.
// ----------------------------------------------------------------------------
module fsa_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [3:0]                 cmd,
  input  logic [31:0]                in_num,
  input  logic [30:0]                in_den,
  output fsa_pkg::fsa_status_t       status,
  output logic [31:0]                acc_num,
  output logic [30:0]                acc_den,
  output logic                       ovf
);
  import fsa_pkg::*;

  logic [30:0] ga, gb;
  logic [30:0] lcm, q;
  logic [30:0] dvd, dvs, quo, rem;
  logic [CntW-1:0] cnt;
  logic [31:0] p1;
  logic [31:0] xn;
  logic [30:0] xd;

  logic [31:0] trial;
  logic [62:0] mul_u;
  logic signed [63:0] mul_s;
  logic signed [32:0] sum;

  assign trial = {rem, dvd[30]} - {1'b0, dvs};
  assign mul_u = {32'd0, quo} * {32'd0, xd};
  assign mul_s = $signed(xn) * $signed({1'b0, q});
  assign sum   = $signed({p1[31], p1}) + $signed({mul_s[31], mul_s[31:0]});

  assign status.div_done = (cnt == CntW'(DenW));
  assign status.gcd_zero = (gb == '0);
  assign status.den_zero = (acc_den == '0) || (xd == '0);
  assign status.lcm_zero = (lcm == '0);

  // Command-driven register updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_num <= '0;
      acc_den <= 31'd1;
      ovf     <= 1'b0;
      cnt     <= '0;
    end else begin
      case (cmd)
        CmdLoad: begin
          acc_num <= in_num;
          acc_den <= in_den;
          xn      <= in_num;
          xd      <= in_den;
          ovf     <= (in_den == '0);
        end
        CmdGcdInit: begin
          xn <= in_num;
          xd <= in_den;
          ga <= acc_den;
          gb <= in_den;
          if (in_den == '0) ovf <= 1'b1;
        end
        CmdDivInit: begin
          dvd <= ga; dvs <= gb; rem <= '0; quo <= '0; cnt <= '0;
        end
        CmdDivStep: begin
          cnt <= cnt + 1'b1;
          dvd <= {dvd[29:0], 1'b0};
          if (!trial[31]) begin
            rem <= trial[30:0];
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= {rem[29:0], dvd[30]};
            quo <= {quo[29:0], 1'b0};
          end
        end
        CmdGcdNext: begin
          ga <= gb; gb <= rem;
        end
        CmdLcmDiv1: begin
          dvd <= acc_den; dvs <= ga; rem <= '0; quo <= '0; cnt <= '0;
        end
        CmdLcmMul: begin
          lcm <= mul_u[30:0];
          if (mul_u[62:31] != '0) ovf <= 1'b1;
        end
        CmdQ1Div: begin
          dvd <= lcm; dvs <= xd; rem <= '0; quo <= '0; cnt <= '0;
        end
        CmdSaveQ: q <= quo;
        CmdMul1: begin
          p1 <= mul_s[31:0];
          if (mul_s != 64'(signed'(mul_s[31:0]))) ovf <= 1'b1;
        end
        CmdQ2Div: begin
          xn <= acc_num;
          dvd <= lcm; dvs <= acc_den; rem <= '0; quo <= '0; cnt <= '0;
        end
        CmdMul2: begin
          if (mul_s != 64'(signed'(mul_s[31:0]))) ovf <= 1'b1;
          if (sum[32] != sum[31]) ovf <= 1'b1;
          acc_num <= sum[31:0];
          acc_den <= lcm;
        end
        CmdZero: begin
          acc_num <= '0; acc_den <= '0; ovf <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/fsa_ctrl.sv
// ----------------------------------------------------------------------------
// fsa_ctrl: sequencer for the fraction sum accumulator
// Steps the datapath through load, Euclid's GCD, lcm, scaling and sum.
// ----------------------------------------------------------------------------
module fsa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 in_last,
  input  logic                 out_busy,
  input  fsa_pkg::fsa_status_t status,
  output logic [3:0]           cmd,
  output logic                 in_ready,
  output logic                 emit
);
  import fsa_pkg::*;

  localparam logic [3:0] SIdle = 4'd0, SGcdChk = 4'd1, SGcdDiv = 4'd2,
    SGcdNext = 4'd3, SLcmDiv = 4'd4, SLcmMul = 4'd5, SQ1Div = 4'd6,
    SMul1 = 4'd8, SQ2Div = 4'd9, SQ2Save = 4'd10,
    SMul2 = 4'd11, SDone = 4'd12, SDenChk = 4'd13;

  logic [3:0] state, state_next;
  logic in_seq, last;

  assign in_ready = (state == SIdle) && !out_busy;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = CmdIdle;
    emit = 1'b0;
    unique case (state)
      SIdle: if (in_fire) begin
        if (!in_seq) begin cmd = CmdLoad; state_next = SDone; end
        else begin cmd = CmdGcdInit; state_next = SDenChk; end
      end
      SDenChk: if (status.den_zero) begin
        cmd = CmdZero; state_next = SDone;
      end else state_next = SGcdChk;
      SGcdChk: if (status.gcd_zero) begin
        cmd = CmdLcmDiv1; state_next = SLcmDiv;
      end else begin cmd = CmdDivInit; state_next = SGcdDiv; end
      SGcdDiv: if (status.div_done) begin
        cmd = CmdGcdNext; state_next = SGcdChk;
      end else cmd = CmdDivStep;
      SLcmDiv: if (status.div_done) begin
        cmd = CmdLcmMul; state_next = SLcmMul;
      end else cmd = CmdDivStep;
      SLcmMul: if (status.lcm_zero) begin
        cmd = CmdZero; state_next = SDone;
      end else begin cmd = CmdQ1Div; state_next = SQ1Div; end
      SQ1Div: if (status.div_done) begin
        cmd = CmdSaveQ; state_next = SMul1;
      end else cmd = CmdDivStep;
      SMul1: begin cmd = CmdMul1; state_next = SQ2Div; end
      SQ2Div: begin cmd = CmdQ2Div; state_next = SQ2Save; end
      SQ2Save: if (status.div_done) begin
        cmd = CmdSaveQ; state_next = SMul2;
      end else cmd = CmdDivStep;
      SMul2: begin cmd = CmdMul2; state_next = SDone; end
      SDone: begin emit = last; state_next = SIdle; end
      default: state_next = SIdle;
    endcase
  end

  // State and sequence tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      in_seq <= 1'b0;
      last <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        last <= in_last;
        in_seq <= !in_last;
      end
    end
  end

endmodule

FILE: test/fraction_sum_accumulator_tb.sv
// ----------------------------------------------------------------------------
// fraction_sum_accumulator_tb: self-checking testbench
// Drives fraction sequences into the accumulator over the input stream and
// checks each returned sum against a predictor of the lcm addition, with
// random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------
module fraction_sum_accumulator_tb;
  import fsa_pkg::*;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic            ovf;
  } frac_sum_t;

  typedef struct {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic            last;
    logic            has_sum;
    frac_sum_t       sum;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        m_tuser;

  // Running sum held by the predictor.
  logic signed [NumW-1:0] sum_num;
  logic [DenW-1:0]        sum_den;
  logic                   sum_open;
  logic                   sum_ovf;

  frac_sum_t   sums_pending[$];
  stim_row_t   directed[$];
  int          errors;
  bit          calm;

  fraction_sum_accumulator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit that fails the test if it has not finished by this time.
  initial begin
    #40000000;
    $display("FAIL fraction_sum_accumulator");
    $finish;
  end

  function automatic logic [63:0] euclid_gcd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Wraps a 64-bit signed value to the numerator width, noting overflow.
  function automatic logic signed [NumW-1:0] fit_num(input longint v, inout logic f);
    logic signed [NumW-1:0] r;
    r = v[NumW-1:0];
    if (longint'(r) != v) f = 1'b1;
    return r;
  endfunction

  // Updates the running sum with one fraction; returns 1 when a sum is due.
  function automatic bit add_fraction(input logic [NumW-1:0] n, input logic [DenW-1:0] d,
                                      input logic last, output frac_sum_t res);
    logic        f;
    logic [63:0] g, lcm, prod;
    longint      p1, p2;
    logic signed [NumW-1:0] q1, q2;
    f = (d == 0);
    if (!sum_open) begin
      sum_num = n;
      sum_den = d;
      sum_ovf = f;
    end else begin
      if (sum_den == 0 || d == 0) begin
        sum_num = '0;
        sum_den = '0;
        f = 1'b1;
      end else begin
        g = euclid_gcd(64'(sum_den), 64'(d));
        prod = (64'(sum_den) / g) * 64'(d);
        lcm = 64'(prod[DenW-1:0]);
        if (lcm != prod) f = 1'b1;
        if (lcm == 0) begin
          sum_num = '0;
          sum_den = '0;
          f = 1'b1;
        end else begin
          p1 = longint'(sum_num) * longint'(lcm / 64'(sum_den));
          p2 = longint'($signed(n)) * longint'(lcm / 64'(d));
          q1 = fit_num(p1, f);
          q2 = fit_num(p2, f);
          sum_num = fit_num(longint'(q1) + longint'(q2), f);
          sum_den = lcm[DenW-1:0];
        end
      end
      sum_ovf = sum_ovf | f;
    end
    sum_open = !last;
    res = '{sum_num, sum_den, sum_ovf};
    return last;
  endfunction

  // Sends one fraction and records its expected sum, if any.
  task automatic send_fraction(input stim_row_t row);
    frac_sum_t res;
    bit        due;
    while (!calm && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row.den, row.num};
    s_tlast  <= row.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = add_fraction(row.num, row.den, row.last, res);
    if (due) begin
      if (row.has_sum && res !== row.sum) begin
        $display("%0t table mismatch: expected %h actual %h", $time, row.sum, res);
        errors++;
      end
      sums_pending.push_back(res);
    end
  endtask

  // Sum checker and receiver stalls.
  always @(posedge clk) begin
    frac_sum_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[31:0], m_tdata[62:32], m_tuser};
        if (sums_pending.size() == 0) begin
          $display("%0t unexpected sum: actual %h", $time, got);
          errors++;
        end else begin
          want = sums_pending.pop_front();
          if (got.num !== want.num || got.den !== want.den || got.ovf !== want.ovf) begin
            $display("%0t sum mismatch: expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
    end
    m_tready <= calm || ($urandom_range(99) >= 30);
  end

  function automatic stim_row_t row_of(input logic [31:0] n, input logic [30:0] d,
                                       input logic l);
    stim_row_t r;
    r = '{n, d, l, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t row_sum(input logic [31:0] n, input logic [30:0] d,
                                        input frac_sum_t s);
    stim_row_t r;
    r = '{n, d, 1'b1, 1'b1, s};
    return r;
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0: return 31'($urandom_range(1, 16));
      1: return 31'($urandom_range(1, 1000));
      2: return 31'($urandom_range(1, 65535));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(2))
      0: return 32'($signed($urandom_range(0, 40)) - 20);
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, len;
    errors = 0;
    calm = 1'b0;
    sum_num = '0;
    sum_den = 31'd1;
    sum_open = 1'b0;
    sum_ovf = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table: lone items, extremes, zero denominators, wrapping.
    directed.push_back(row_sum(32'h7fffffff, 31'h7fffffff, '{32'h7fffffff, 31'h7fffffff, 1'b0}));
    directed.push_back(row_sum(32'h80000000, 31'd1, '{32'h80000000, 31'd1, 1'b0}));
    directed.push_back(row_sum(32'd5, 31'd0, '{32'd5, 31'd0, 1'b1}));
    directed.push_back(row_sum(32'h0, 31'd1, '{32'h0, 31'd1, 1'b0}));
    directed.push_back(row_of(32'd1, 31'd2, 1'b0));
    directed.push_back(row_sum(32'd1, 31'd3, '{32'd5, 31'd6, 1'b0}));
    directed.push_back(row_of(32'd3, 31'd0, 1'b0));
    directed.push_back(row_sum(32'd1, 31'd3, '{32'd0, 31'd0, 1'b1}));
    directed.push_back(row_of(32'd1, 31'd4, 1'b0));
    directed.push_back(row_sum(32'd1, 31'd0, '{32'd0, 31'd0, 1'b1}));
    directed.push_back(row_of(32'h7fffffff, 31'd1, 1'b0));
    directed.push_back(row_sum(32'd1, 31'd1, '{32'h80000000, 31'd1, 1'b1}));
    directed.push_back(row_of(32'h80000000, 31'd1, 1'b0));
    directed.push_back(row_of(32'hffffffff, 31'd1, 1'b0));
    directed.push_back(row_of(32'd3, 31'h7fffffff, 1'b0));
    directed.push_back(row_of(32'd1, 31'h7ffffffe, 1'b1));
    directed.push_back(row_of(32'd7, 31'h40000000, 1'b0));
    directed.push_back(row_of(32'hfffffff9, 31'h2aaaaaaa, 1'b0));
    directed.push_back(row_of(32'h12345678, 31'h55555555, 1'b0));
    directed.push_back(row_of(32'hdeadbeef, 31'd12, 1'b1));
    directed.push_back(row_of(32'd9, 31'd6, 1'b0));
    directed.push_back(row_of(32'hfffffffb, 31'd10, 1'b1));
    foreach (directed[i]) send_fraction(directed[i]);
    s_tvalid <= 1'b0;

    // Hold off until the block has returned every sum.
    while (sums_pending.size() != 0) @(posedge clk);

    // Random sequences, mostly short; one calm stretch without idling.
    n = 0;
    while (n < 1400) begin
      calm = (n >= 600 && n < 750);
      len = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
      for (int k = 0; k < len; k++) begin
        send_fraction(row_of(rand_num(), ($urandom_range(49) == 0) ? 31'd0 : rand_den(),
                             k == len - 1));
        n++;
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (sums_pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("PASS fraction_sum_accumulator");
    end else begin
      $display("FAIL fraction_sum_accumulator");
    end
    $finish;
  end

endmodule
